// ===== hdl/hfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, constants and helper functions for the humidity frame decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

   localparam logic [7:0]  CRC_POLY   = 8'h31;
   localparam logic [7:0]  CRC_INIT   = 8'hFF;
   localparam logic [14:0] TEMP_SPAN  = 15'd17500;
   localparam logic [13:0] HUM_SPAN   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] FULL_SCALE = 17'd65535;

   // Stage one result: CRC state after the high bytes and the scaled raw words.
   typedef struct packed {
      logic [7:0]  crc_t;
      logic [7:0]  crc_h;
      logic [7:0]  temp_low;
      logic [7:0]  hum_low;
      logic [7:0]  temp_check;
      logic [7:0]  hum_check;
      logic [30:0] prod_t;
      logic [29:0] prod_h;
   } s1_type;

   // Stage two result: check outcome and the quotients.
   typedef struct packed {
      logic        ok;
      logic [14:0] quo_t;
      logic [13:0] quo_h;
   } s2_type;

   // Result beat.
   typedef struct packed {
      logic        status;
      logic [14:0] temp_centi;
      logic [13:0] hum_centi;
   } rsp_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Floor division by 65535. With x = a*65536 + b, x = a*65535 + (a + b),
   // and a + b stays below twice the divisor, so one compare corrects it.
   function automatic logic [14:0] div_full_scale(input logic [30:0] x);
      logic [16:0] s;
      logic [14:0] a;
      a = x[30:16];
      s = {2'b00, a} + {1'b0, x[15:0]};
      return a + {14'd0, (s >= FULL_SCALE)};
   endfunction

endpackage

// ===== hdl/hfd_stage_head.sv =====
// ----------------------------------------------------------------------------
// hfd_stage_head
// First pipeline stage: CRC over the high bytes and scaling multiplies.
// ----------------------------------------------------------------------------
module hfd_stage_head (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [47:0]        in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hfd_pkg::s1_type    out_data
);

   logic            valid_ff;
   logic            valid_in;
   hfd_pkg::s1_type data_ff;
   hfd_pkg::s1_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.crc_t      = hfd_pkg::crc8_byte(hfd_pkg::CRC_INIT, in_data[7:0]);
      data_in.crc_h      = hfd_pkg::crc8_byte(hfd_pkg::CRC_INIT, in_data[31:24]);
      data_in.temp_low   = in_data[15:8];
      data_in.temp_check = in_data[23:16];
      data_in.hum_low    = in_data[39:32];
      data_in.hum_check  = in_data[47:40];
      data_in.prod_t     = {16'd0, hfd_pkg::TEMP_SPAN} * {15'd0, in_data[7:0], in_data[15:8]};
      data_in.prod_h     = {16'd0, hfd_pkg::HUM_SPAN} * {14'd0, in_data[31:24], in_data[39:32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/hfd_stage_check.sv =====
// ----------------------------------------------------------------------------
// hfd_stage_check
// Second pipeline stage: CRC over the low bytes, check compare, division.
// ----------------------------------------------------------------------------
module hfd_stage_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hfd_pkg::s1_type    in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hfd_pkg::s2_type    out_data
);

   logic            valid_ff;
   logic            valid_in;
   hfd_pkg::s2_type data_ff;
   hfd_pkg::s2_type data_in;
   logic [14:0]     quo_h_wide;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.ok = (hfd_pkg::crc8_byte(in_data.crc_t, in_data.temp_low) == in_data.temp_check)
                && (hfd_pkg::crc8_byte(in_data.crc_h, in_data.hum_low) == in_data.hum_check);
      data_in.quo_t = hfd_pkg::div_full_scale(in_data.prod_t);
      quo_h_wide    = hfd_pkg::div_full_scale({1'b0, in_data.prod_h});
      data_in.quo_h = quo_h_wide[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/hfd_stage_out.sv =====
// ----------------------------------------------------------------------------
// hfd_stage_out
// Third pipeline stage: temperature offset, error zeroing, output register.
// ----------------------------------------------------------------------------
module hfd_stage_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hfd_pkg::s2_type    in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hfd_pkg::rsp_type   out_data
);

   logic             valid_ff;
   logic             valid_in;
   hfd_pkg::rsp_type data_ff;
   hfd_pkg::rsp_type data_in;
   logic [15:0]      temp_wide;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      temp_wide = {1'b0, in_data.quo_t} - hfd_pkg::TEMP_OFFSET;
      data_in.status     = !in_data.ok;
      data_in.temp_centi = in_data.ok ? temp_wide[14:0] : 15'd0;
      data_in.hum_centi  = in_data.ok ? in_data.quo_h : 14'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/humidity_frame_decode_top.sv =====
// ----------------------------------------------------------------------------
// humidity_frame_decode_top
// Beats pass the three stages head, check and out in turn, one beat per stage.
// Throughput is one frame per cycle unless the response side stalls.
// The stages are elastic, so a stalled response blocks only the full stages.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module humidity_frame_decode_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: temp_high, temp_low, temp_check,
   // hum_high, hum_low, hum_check (eight bits each).
   input  logic [47:0] req_tdata,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: temp_centi (15 bits, signed), hum_centi (14 bits),
   // then three zero pad bits.
   output logic [31:0] rsp_tdata,
   // Fields from bit 0 up: status (1 bit, set on a CRC mismatch).
   output logic        rsp_tuser
);

   // Stage one computes the CRC state after each high byte and multiplies
   // the raw words by their spans. Stage two finishes each CRC with the low
   // byte, compares against the received check bytes and divides by the full
   // scale value. Stage three applies the temperature offset, forces zeros on
   // a mismatch and serves as the output register.

   logic             s1_valid;
   logic             s1_ready;
   hfd_pkg::s1_type  s1_data;
   logic             s2_valid;
   logic             s2_ready;
   hfd_pkg::s2_type  s2_data;
   hfd_pkg::rsp_type rsp_data;

   hfd_stage_head u_head (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   hfd_stage_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   hfd_stage_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Pack the response beat; the pad bits are held at zero.
   assign rsp_tdata = {3'b000, rsp_data.hum_centi, rsp_data.temp_centi};
   assign rsp_tuser = rsp_data.status;

endmodule

// ===== dv/humidity_frame_decode_top_test.sv =====
// ----------------------------------------------------------------------------
// humidity_frame_decode_top_test
// Self-checking bench for the sensor frame decoder. Frames are queued by a
// stimulus process and streamed in by a clocked driver. A monitor compares
// every response beat with the reading that the bench predicts for each
// accepted frame. Both sides idle at random, the receiver holds off once for
// a long stretch, and the sender drains the pipeline between phases.
// ----------------------------------------------------------------------------
module humidity_frame_decode_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   // CRC-8 generator and conversion constants of the sensor protocol.
   localparam logic [7:0] SENSOR_CRC_POLY = 8'h31;
   localparam logic [7:0] SENSOR_CRC_SEED = 8'hFF;
   localparam longint     RAW_MAX         = 65535;
   localparam longint     TEMP_SPAN_CENTI = 17500;
   localparam longint     TEMP_BIAS_CENTI = 4500;
   localparam longint     HUM_SPAN_CENTI  = 10000;

   // Run shape.
   localparam int IDLE_PERCENT     = 26;
   localparam int CALM_FIRST_CYCLE = 1200;   // no idling on either side from here
   localparam int CALM_LAST_CYCLE  = 1900;   // up to here
   localparam int HOLD_AFTER_BEATS = 400;    // receiver hold-off starts after this many
   localparam int HOLD_CYCLES      = 250;
   localparam int STALL_LIMIT      = 3000;   // cycles without any beat before giving up
   localparam int TAIL_CYCLES      = 8;

   // One decoded reading as the response channel carries it.
   typedef struct packed {
      logic        status;
      logic [14:0] temp_centi;
      logic [13:0] hum_centi;
   } reading_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   // Frames waiting for the driver, and readings waiting for their beat.
   logic [47:0] pending_frames[$];
   reading_type expected_readings[$];

   int cycle_count  = 0;
   int rsp_beats    = 0;
   int stall_cycles = 0;
   int err_cnt      = 0;

   humidity_frame_decode_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The CRC is shifted through the 16 word bits one at a time, MSB first:
   // the feedback bit is the CRC top bit XOR the incoming data bit.
   function automatic logic [7:0] word_crc8(input logic [15:0] word);
      logic [7:0] crc;
      logic       fb;
      crc = SENSOR_CRC_SEED;
      for (int i = 15; i >= 0; i--) begin
         fb  = crc[7] ^ word[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? SENSOR_CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   // Predicts the reading for one frame. Either failed check zeroes both values.
   function automatic reading_type decode_frame(input logic [47:0] frame);
      reading_type r;
      logic [15:0] raw_t;
      logic [15:0] raw_h;
      longint     t;
      longint     h;
      raw_t = {frame[7:0], frame[15:8]};
      raw_h = {frame[31:24], frame[39:32]};
      r = '0;
      if (word_crc8(raw_t) != frame[23:16] || word_crc8(raw_h) != frame[47:40]) begin
         r.status = 1'b1;
      end else begin
         t = (TEMP_SPAN_CENTI * longint'(raw_t)) / RAW_MAX - TEMP_BIAS_CENTI;
         h = (HUM_SPAN_CENTI * longint'(raw_h)) / RAW_MAX;
         r.temp_centi = t[14:0];
         r.hum_centi  = h[13:0];
      end
      return r;
   endfunction

   // Builds a frame from two raw words; a bad word gets a check byte that is
   // guaranteed to differ from the correct one.
   function automatic logic [47:0] make_frame(input logic [15:0] raw_t,
                                              input logic [15:0] raw_h,
                                              input bit bad_t, input bit bad_h);
      logic [7:0] chk_t;
      logic [7:0] chk_h;
      chk_t = word_crc8(raw_t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
      chk_h = word_crc8(raw_h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
      return {chk_h, raw_h[7:0], raw_h[15:8], chk_t, raw_t[7:0], raw_t[15:8]};
   endfunction

   // Mostly uniform raw words, with the scale ends mixed in now and then.
   function automatic logic [15:0] pick_raw();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         return 16'h0000;
      end else if (sel == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   // Random phase: most frames carry correct checks so the conversion path is
   // exercised; the rest break one word or are plain noise.
   task automatic queue_random_frames(input int count);
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 99);
         if (mode < 70) begin
            pending_frames.push_back(make_frame(pick_raw(), pick_raw(), 1'b0, 1'b0));
         end else if (mode < 80) begin
            pending_frames.push_back(make_frame(pick_raw(), pick_raw(), 1'b1, 1'b0));
         end else if (mode < 90) begin
            pending_frames.push_back(make_frame(pick_raw(), pick_raw(), 1'b0, 1'b1));
         end else begin
            pending_frames.push_back({16'($urandom), 32'($urandom)});
         end
      end
   endtask

   // Returns once every queued frame has been sent and every reading has come.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_frames.size() != 0 || req_tvalid || expected_readings.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames: scale ends, midpoints, alternating bit patterns, a
      // failed check on each word and on both, and literal all-zero, all-one and
      // 5AA5 pattern frames whose check bytes are whatever they happen to be.
      pending_frames.push_back(make_frame(16'h0000, 16'h0000, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h0001, 16'h0001, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'hFFFE, 16'hFFFE, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h00FF, 16'hFF00, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h5555, 16'hAAAA, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'hAAAA, 16'h5555, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h6666, 16'h8000, 1'b0, 1'b0));
      pending_frames.push_back(make_frame(16'h1234, 16'hBEEF, 1'b1, 1'b0));
      pending_frames.push_back(make_frame(16'h1234, 16'hBEEF, 1'b0, 1'b1));
      pending_frames.push_back(make_frame(16'h1234, 16'hBEEF, 1'b1, 1'b1));
      pending_frames.push_back(make_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
      pending_frames.push_back(make_frame(16'h0000, 16'hFFFF, 1'b0, 1'b1));
      pending_frames.push_back(48'h0000_0000_0000);
      pending_frames.push_back(48'hFFFF_FFFF_FFFF);
      pending_frames.push_back(48'h5AA5_5AA5_5AA5);

      // The sender waits for the pipeline to empty between phases.
      wait_drained();
      queue_random_frames(900);
      wait_drained();
      queue_random_frames(930);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (err_cnt == 0) begin
         $display("humidity_frame_decode_top_test: clean");
      end else begin
         $display("humidity_frame_decode_top_test: errors");
      end
      $finish;
   end

   // Driver. A beat that is offered stays on the bus until it is taken; the
   // reading it should produce is predicted at the edge that accepts it.
   always @(posedge clock) begin : frame_driver
      bit gap;
      gap = (cycle_count < CALM_FIRST_CYCLE || cycle_count > CALM_LAST_CYCLE) &&
            ($urandom_range(0, 99) < IDLE_PERCENT);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(decode_frame(req_tdata));
         end
         if (req_tvalid && !req_tready) begin
            // Hold the current beat.
         end else if (pending_frames.size() != 0 && !gap) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_frames.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver. Random idling, a calm window, and one long hold-off during
   // which the sender keeps offering frames so the stages fill and the
   // request side backs up.
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin : response_sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_beats >= HOLD_AFTER_BEATS) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (cycle_count >= CALM_FIRST_CYCLE && cycle_count <= CALM_LAST_CYCLE) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Monitor. Each response beat is checked against the oldest prediction.
   always @(posedge clock) begin : reading_monitor
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats <= rsp_beats + 1;
         if (expected_readings.size() == 0) begin
            $error("unexpected response beat: status %0d temp_centi %0d hum_centi %0d",
                   rsp_tuser, $signed(rsp_tdata[14:0]), rsp_tdata[28:15]);
            err_cnt++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               err_cnt++;
            end
            if (rsp_tdata[14:0] !== want.temp_centi) begin
               $error("temp_centi: expected %0d, actual %0d",
                      $signed(want.temp_centi), $signed(rsp_tdata[14:0]));
               err_cnt++;
            end
            if (rsp_tdata[28:15] !== want.hum_centi) begin
               $error("hum_centi: expected %0d, actual %0d", want.hum_centi, rsp_tdata[28:15]);
               err_cnt++;
            end
            if (rsp_tdata[31:29] !== 3'b000) begin
               $error("pad: expected 0, actual %0d", rsp_tdata[31:29]);
               err_cnt++;
            end
         end
      end
   end

   // Watchdog: too long without a beat on either side ends the run.
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("humidity_frame_decode_top_test: errors");
            $finish;
         end
      end
   end

endmodule
